// ===== rtl/mcsd_pkg.sv =====
// shared constants, codes and controller/datapath interface types of the step/dir generator
`timescale 1ns / 1ps
package mcsd_pkg;

  // channel count and speed scaling
  localparam int CHANNELS   = 4;
  localparam int MAX_SPEED  = 1000;
  localparam int MIN_TICKS  = 2;

  // dividend of the period division and the divider sizing
  localparam int PERIOD_NUM = MAX_SPEED * MIN_TICKS;
  localparam int NUM_W      = $clog2(PERIOD_NUM + 1);
  localparam int QUOT_W     = (NUM_W > 17) ? NUM_W : 17;
  localparam int DIV_CNT_W  = $clog2(QUOT_W);

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_SPEED = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic div_start;
    logic div_step;
    logic div_write;
    logic load_out;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_speed;
    logic div_last;
  } dp_status_t;

endpackage

// ===== rtl/mcsd_ctrl.sv =====
// controller state machine sequencing one transaction at a time
`timescale 1ns / 1ps
module mcsd_ctrl
  import mcsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_RESULT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.load_in   = (state == S_IDLE) && in_valid;
    cmd.exec      = (state == S_EXEC) && !status.is_speed;
    cmd.div_start = (state == S_EXEC) && status.is_speed;
    cmd.div_step  = (state == S_DIV);
    cmd.div_write = (state == S_WRITE);
    cmd.load_out  = (state == S_RESULT) && (!out_valid || out_ready);
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= status.is_speed ? S_DIV : S_RESULT;
        end
        S_DIV: begin
          if (status.div_last) state <= S_WRITE;
        end
        S_WRITE: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/mcsd_datapath.sv =====
// channel state, tick and add logic, iterative period divider and output register
`timescale 1ns / 1ps
module mcsd_datapath
  import mcsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  input  logic [1:0]  in_action,
  input  logic [1:0]  in_channel,
  input  logic [31:0] in_step_count,
  input  logic [15:0] in_speed,
  input  dp_cmd_t     cmd,
  output dp_status_t  status,
  output logic [15:0] out_data
);

  localparam logic [15:0] MAX_SPEED16 = 16'(MAX_SPEED);

  // latched transaction
  logic [1:0]  act;
  logic [1:0]  ch;
  logic [31:0] cnt_in;
  logic [15:0] spd_in;

  logic [3:0]  channel_enable;

  // per-channel state
  logic signed [31:0] pend      [CHANNELS];
  logic [15:0]        period    [CHANNELS];
  logic [15:0]        phase     [CHANNELS];
  logic               step_lvl  [CHANNELS];
  logic               dir_lvl   [CHANNELS];

  // tick results
  logic signed [31:0] t_pend    [CHANNELS];
  logic [15:0]        t_phase   [CHANNELS];
  logic               t_step    [CHANNELS];
  logic               t_dir     [CHANNELS];

  // divider
  logic [15:0]          divisor;
  logic [15:0]          rem;
  logic [QUOT_W-1:0]    quot;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [16:0]          trial;
  logic                 trial_ge;
  logic [16:0]          trial_diff;
  logic [15:0]          period_new;

  logic               ch_ok;
  logic [15:0]        spd_clamp;
  logic [32:0]        sum;
  logic signed [31:0] sum_sat;
  logic [CHANNELS-1:0] step_vec, dir_vec, mov_vec;

  assign ch_ok     = (int'(ch) < CHANNELS);
  assign spd_clamp = (spd_in > MAX_SPEED16) ? MAX_SPEED16 : spd_in;

  assign status.is_speed = (act == ACT_SPEED);
  assign status.div_last = (div_cnt == '0);

  // saturating add of the pending count
  always_comb begin
    sum = {pend[ch][31], pend[ch]} + {cnt_in[31], cnt_in};
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // per-channel tick update
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      t_pend[c]  = pend[c];
      t_phase[c] = phase[c] + 16'd1;
      t_step[c]  = step_lvl[c];
      t_dir[c]   = dir_lvl[c];
      if (period[c] == 16'd0) begin
        t_step[c]  = 1'b0;
        t_dir[c]   = pend[c][31];
        t_phase[c] = 16'd0;
      end else if (phase[c] == (period[c] >> 1)) begin
        t_step[c] = 1'b0;
        t_dir[c]  = pend[c][31];
      end else if (phase[c] >= period[c]) begin
        t_phase[c] = 16'd1;
        if (pend[c] > 0) begin
          t_step[c] = 1'b1;
          t_pend[c] = pend[c] - 32'sd1;
        end else if (pend[c] < 0) begin
          t_step[c] = 1'b1;
          t_pend[c] = pend[c] + 32'sd1;
        end
      end
    end
  end

  // one restoring division step
  always_comb begin
    trial      = {rem, quot[QUOT_W-1]};
    trial_ge   = (trial >= {1'b0, divisor});
    trial_diff = trial - {1'b0, divisor};
    if (divisor == 16'd0) begin
      period_new = 16'd0;
    end else if (|quot[QUOT_W-1:16]) begin
      period_new = 16'hFFFF;
    end else begin
      period_new = quot[15:0];
    end
  end

  // input latch and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act    <= in_action;
      ch     <= in_channel;
      cnt_in <= in_step_count;
      spd_in <= in_speed;
    end
    if (cmd.div_start) begin
      divisor <= spd_clamp;
      rem     <= 16'd0;
      quot    <= QUOT_W'(PERIOD_NUM);
      div_cnt <= DIV_CNT_W'(QUOT_W - 1);
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? trial_diff[15:0] : trial[15:0];
      quot    <= {quot[QUOT_W-2:0], trial_ge};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable <= 4'd0;
    end else if (cfg_wen) begin
      channel_enable <= cfg_wdata;
    end
  end

  // channel state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pend[c]     <= '0;
        period[c]   <= '0;
        phase[c]    <= '0;
        step_lvl[c] <= 1'b0;
        dir_lvl[c]  <= 1'b0;
      end
    end else begin
      if (cmd.exec && act == ACT_TICK) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (channel_enable[c]) begin
            pend[c]     <= t_pend[c];
            phase[c]    <= t_phase[c];
            step_lvl[c] <= t_step[c];
            dir_lvl[c]  <= t_dir[c];
          end
        end
      end
      if (cmd.exec && act == ACT_ADD && ch_ok) begin
        pend[ch] <= sum_sat;
      end
      if (cmd.div_write && ch_ok) begin
        period[ch] <= period_new;
      end
    end
  end

  // pin snapshot
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      step_vec[c] = step_lvl[c];
      dir_vec[c]  = dir_lvl[c];
      mov_vec[c]  = (pend[c] != 0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {4'd0, mov_vec, dir_vec, step_vec};
    end
  end

endmodule

// ===== rtl/multi_channel_step_dir_generator_top.sv =====
// top level of the multi-channel step/direction pulse generator
//
//  channel   dir  signals                               contents
//  s_axis    in   tvalid tready tdata[47:0] tuser[3:0]  command: action, channel, count, speed
//  m_axis    out  tvalid tready tdata[15:0]             pin levels after the command
//  cfg       in   cfg_wen cfg_wdata[3:0]                channel enable mask
//
// one command at a time: tick and add-steps pass through the exec and result states;
// set-speed also runs the one-bit-per-cycle divider and a write step before the result.
// a waiting result sits in the output register; the next command is accepted
// once the controller is back in idle, even while that result is not yet taken.
// rst is synchronous and clears all channel state, the enable mask and the output valid.
`timescale 1ns / 1ps
module multi_channel_step_dir_generator_top
  import mcsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // step_count[31:0], speed[47:32]
  input  logic [3:0]  s_axis_tuser,   // action[1:0], channel[3:2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // step_pins[3:0], dir_pins[7:4], moving[11:8], zero[15:12]
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  mcsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // channel state and divider
  mcsd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_action     (s_axis_tuser[1:0]),
    .in_channel    (s_axis_tuser[3:2]),
    .in_step_count (s_axis_tdata[31:0]),
    .in_speed      (s_axis_tdata[47:32]),
    .cmd           (cmd),
    .status        (status),
    .out_data      (m_axis_tdata)
  );

endmodule

// ===== rtl/mcsd_checker.sv =====
// port-level checks of the step/dir generator and their binding to the top level
`timescale 1ns / 1ps
module mcsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // no result is offered right out of reset
  a_reset_idle: assert property (@(posedge clk) $fell(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // one command in flight: input closes after each transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted transaction");

  // the next command is not accepted before the result of the last one is formed
  a_result_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> ##1 !s_axis_tready)
    else $error("input ready before the result of a command was formed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind multi_channel_step_dir_generator_top mcsd_checker u_mcsd_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench of the multi-channel step/direction pulse generator
`timescale 1ns / 1ps
module testbench;
  import mcsd_pkg::*;

  // action code with no meaning to the block
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 190;

  // pin levels of one result, field order as in m_axis_tdata
  typedef struct packed {
    logic [3:0] pad;
    logic [3:0] moving;
    logic [3:0] dir;
    logic [3:0] step;
  } pin_state_t;

  // predicts the pin levels of every command and checks them in order
  class pin_scoreboard;
    logic signed [31:0] pend_steps [CHANNELS];
    logic [15:0] period [CHANNELS];
    logic [15:0] phase [CHANNELS];
    logic [3:0] step_lvl;
    logic [3:0] dir_lvl;
    logic [3:0] enable;
    pin_state_t expected_pins [$];
    int errors;
    int checked;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        pend_steps[c] = '0;
        period[c] = '0;
        phase[c] = '0;
      end
      step_lvl = '0;
      dir_lvl = '0;
      enable = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void set_enable(logic [3:0] mask);
      enable = mask;
    endfunction

    function void report_mismatch(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endfunction

    // one tick of one enabled channel
    function void advance_channel(int c);
      if (period[c] == 16'd0) begin
        // stopped channel: pin low, direction follows the sign, phase cleared
        step_lvl[c] = 1'b0;
        dir_lvl[c] = pend_steps[c][31];
        phase[c] = 16'd0;
      end else begin
        if (phase[c] == (period[c] >> 1)) begin
          step_lvl[c] = 1'b0;
          dir_lvl[c] = pend_steps[c][31];
        end else if (phase[c] >= period[c]) begin
          phase[c] = 16'd0;
          if (pend_steps[c] > 0) begin
            step_lvl[c] = 1'b1;
            pend_steps[c] = pend_steps[c] - 1;
          end else if (pend_steps[c] < 0) begin
            step_lvl[c] = 1'b1;
            pend_steps[c] = pend_steps[c] + 1;
          end
        end
        phase[c] = phase[c] + 16'd1;
      end
    endfunction

    // accepted command: update the state and queue the expected pins
    function void note_command(logic [1:0] act, logic [1:0] ch, logic signed [31:0] count,
                               logic [15:0] speed);
      longint sum;
      int unsigned spd;
      int unsigned quot;
      pin_state_t pins;
      case (act)
        ACT_TICK: begin
          for (int c = 0; c < CHANNELS; c++)
            if (enable[c]) advance_channel(c);
        end
        ACT_ADD: begin
          // saturating add at the 32-bit signed limits
          sum = longint'(pend_steps[ch]) + longint'(count);
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          if (sum < -64'sd2147483648) sum = -64'sd2147483648;
          pend_steps[ch] = sum[31:0];
        end
        ACT_SPEED: begin
          spd = 32'(speed);
          if (spd > MAX_SPEED) spd = MAX_SPEED;
          quot = 0;
          if (spd != 0) begin
            quot = PERIOD_NUM / spd;
            if (quot > 32'hFFFF) quot = 32'hFFFF;
          end
          period[ch] = quot[15:0];
        end
        default: ;
      endcase
      pins.pad = '0;
      pins.step = step_lvl;
      pins.dir = dir_lvl;
      for (int c = 0; c < CHANNELS; c++) pins.moving[c] = (pend_steps[c] != 0);
      expected_pins.push_back(pins);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(logic [15:0] data);
      pin_state_t got;
      pin_state_t want;
      got = data;
      checked++;
      if (expected_pins.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected: %h", checked, data));
        return;
      end
      want = expected_pins.pop_front();
      if (got.step !== want.step)
        report_mismatch($sformatf("result %0d step_pins %b, expected %b",
                                  checked, got.step, want.step));
      if (got.dir !== want.dir)
        report_mismatch($sformatf("result %0d dir_pins %b, expected %b",
                                  checked, got.dir, want.dir));
      if (got.moving !== want.moving)
        report_mismatch($sformatf("result %0d moving %b, expected %b",
                                  checked, got.moving, want.moving));
      if (got.pad !== want.pad)
        report_mismatch($sformatf("result %0d padding bits %b, expected zero",
                                  checked, got.pad));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // step_count[31:0], speed[47:32]
  logic [3:0]  s_axis_tuser = '0;   // action[1:0], channel[3:2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // step_pins[3:0], dir_pins[7:4], moving[11:8], zero[15:12]

  pin_scoreboard sb = new();
  bit quiet = 1'b0;
  int cycles = 0;
  int sent_count [4] = '{0, 0, 0, 0};
  int enable_settings = 0;

  multi_channel_step_dir_generator_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check each transaction, stall at random unless quiet
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 37);
  end

  // offer one command and wait for its transaction
  task automatic send_command(logic [1:0] act, logic [1:0] ch, logic [31:0] count,
                              logic [15:0] speed);
    if (!quiet && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tuser <= {ch, act};
    s_axis_tdata <= {speed, count};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_command(act, ch, count, speed);
    sent_count[act]++;
  endtask

  // stop offering and wait until every result is in and the block has settled
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_pins.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // enable mask write, only while idle
  task automatic write_enable(logic [3:0] mask);
    cfg_wen <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_enable(mask);
    enable_settings++;
  endtask

  // step count: mostly short moves, some medium, a few full-range values
  function automatic logic [31:0] pick_count();
    int unsigned r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 70) v = $urandom_range(0, 20);
    else if (r < 90) v = $urandom_range(0, 5000);
    else return $urandom;
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // speed: mostly fast enough to step often, some stops, some full-range values
  function automatic logic [15:0] pick_speed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(200, 1000));
    if (r < 75) return 16'd0;
    return 16'($urandom_range(0, 65535));
  endfunction

  // one random command, mostly ticks so that the channels keep stepping
  task automatic send_random;
    int unsigned r;
    logic [31:0] count;
    logic [15:0] speed;
    logic [1:0] ch;
    r = $urandom_range(0, 99);
    count = $urandom;
    speed = 16'($urandom_range(0, 65535));
    ch = 2'($urandom_range(0, 3));
    if (r < 65) begin
      send_command(ACT_TICK, ch, count, speed);
    end else if (r < 80) begin
      send_command(ACT_ADD, ch, pick_count(), speed);
    end else if (r < 95) begin
      send_command(ACT_SPEED, ch, count, pick_speed());
    end else begin
      send_command(ACT_NONE, ch, count, speed);
    end
  endtask

  // main sequence
  initial begin
    logic [3:0] masks [8];
    masks = '{4'hF, 4'h0, 4'h5, 4'hF, 4'hA, 4'h0, 4'h0, 4'hF};
    masks[5] = 4'($urandom_range(0, 15));
    masks[6] = 4'($urandom_range(0, 15));

    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: commands land on disabled channels first
    write_enable(4'h0);
    send_command(ACT_TICK, 2'd0, 32'h0, 16'h0);
    send_command(ACT_ADD, 2'd0, 32'h7FFF_FFFF, 16'hFFFF);
    send_command(ACT_ADD, 2'd0, 32'd5, 16'h0);
    send_command(ACT_ADD, 2'd1, 32'h8000_0000, 16'h0);
    send_command(ACT_ADD, 2'd1, 32'hFFFF_FFFF, 16'h0);
    send_command(ACT_SPEED, 2'd0, 32'hFFFF_FFFF, 16'd0);
    send_command(ACT_SPEED, 2'd1, 32'h0, 16'hFFFF);
    send_command(ACT_SPEED, 2'd2, 32'h0, 16'd1);
    send_command(ACT_SPEED, 2'd3, 32'h0, 16'd1000);
    send_command(ACT_ADD, 2'd2, 32'd3, 16'h0);
    send_command(ACT_ADD, 2'd3, -32'sd3, 16'h0);
    send_command(ACT_NONE, 2'd3, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(ACT_TICK, 2'd0, 32'hFFFF_FFFF, 16'hFFFF);
    drain();

    // directed: all channels run, stopped and saturated ones among them
    write_enable(4'hF);
    send_command(ACT_ADD, 2'd0, 32'h8000_0000, 16'h0);
    send_command(ACT_SPEED, 2'd2, 32'h0, 16'd1001);
    for (int i = 0; i < 8; i++) send_command(ACT_TICK, 2'(i), 32'h0, 16'h0);
    send_command(ACT_SPEED, 2'd0, 32'h0, 16'd500);
    send_command(ACT_NONE, 2'd0, 32'h0, 16'h0);
    drain();

    // random phases over several enable settings, one of them without idling
    foreach (masks[p]) begin
      write_enable(masks[p]);
      quiet = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
      drain();
      quiet = 1'b0;
    end

    $display("covered %0d ticks, %0d add-steps, %0d set-speed, %0d unknown commands",
             sent_count[0], sent_count[1], sent_count[2], sent_count[3]);
    $display("over %0d enable settings, %0d results checked, %0d mismatches",
             enable_settings, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mcsd_pkg.sv
rtl/mcsd_ctrl.sv
rtl/mcsd_datapath.sv
rtl/multi_channel_step_dir_generator_top.sv
rtl/mcsd_checker.sv
tb/testbench.sv
